// File: rtl/core/pmfa_pkg.sv
// pmfa_pkg: shared types, codes and the per-axis rest filter / boost function
// for the pointer motion filter accumulator; depends on nothing else
`timescale 1ns / 1ps

package pmfa_pkg;

   // request action codes
   typedef enum logic [0:0] {
      ACT_SAMPLE = 1'b0,
      ACT_READ   = 1'b1
   } action_type;

   // response status codes
   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_EMPTY   = 2'd1,
      ST_IGNORED = 2'd2
   } status_type;

   // control register indexes
   typedef enum logic [1:0] {
      REG_CLAMP_LIMIT = 2'd0,
      REG_SMALL_MOVE  = 2'd1,
      REG_BOOST_BELOW = 2'd2,
      REG_BOOST_GAIN  = 2'd3
   } reg_index_type;

   localparam logic [7:0] CLAMP_LIMIT_RST = 8'd96;
   localparam logic [7:0] SMALL_MOVE_RST  = 8'd2;
   localparam logic [7:0] BOOST_BELOW_RST = 8'd80;
   localparam logic [3:0] BOOST_GAIN_RST  = 4'd4;

   // result of filtering one clamped axis
   typedef struct packed {
      logic signed [12:0] val;    // filtered and boosted value
      logic               rest;   // axis was zero: mark rest in slot
      logic               jitter; // small move: clear slot
   } axis_result_type;

   // one response beat
   typedef struct packed {
      status_type         status;
      logic signed [31:0] x;
      logic signed [31:0] y;
   } rsp_beat_type;

   // rest filter then boost for one axis (|v| <= 255, so 13 bits hold v * 15)
   function automatic axis_result_type filter_axis(
      input logic signed [8:0] v,
      input logic              all_rest,
      input logic [7:0]        small_limit,
      input logic [7:0]        boost_below,
      input logic [3:0]        boost_gain
   );
      axis_result_type    r;
      logic [7:0]         mag;
      logic signed [12:0] v13;
      mag = v[8] ? 8'(-v) : v[7:0];
      v13 = 13'(v);
      r.rest   = (mag == 8'd0);
      r.jitter = !r.rest && (mag <= small_limit);
      if (r.jitter && all_rest) begin
         v13 = '0;
         mag = '0;
      end
      if (mag < boost_below) begin
         r.val = v13 * $signed({9'd0, boost_gain});
      end else begin
         r.val = v13;
      end
      return r;
   endfunction

endpackage

// File: rtl/core/pointer_motion_filter_accumulator.sv
// pointer_motion_filter_accumulator: top level, input stage, filter logic,
// running sums and a three-entry response buffer; depends on pmfa_pkg
`timescale 1ns / 1ps

// Usage
//   req_ channel: one beat is a motion sample (req_action = sample, with
//   req_delta_x / req_delta_y) or a read-and-clear request. Every beat gives
//   exactly one rsp_ beat (status, out_x, out_y), in order.
//   csr_ channel: writes one of four control registers (clamp limit, small
//   move limit, boost threshold, boost gain); always ready. Write only while
//   the block is idle.
//   Path: a beat accepted on req_ passes the input register, then the
//   response buffer, before it can be taken on rsp_.
//   Throughput: one beat per cycle while req_ready is high. All filtering,
//   the history update and the sum add are combinational from the input
//   register and captured together, so state is current for the next beat.
//   Stall: the response buffer holds three beats; req_ready drops when the
//   buffer plus the input register hold three beats, and rises again as
//   rsp_ beats are taken. Nothing is lost while the receiver stalls.
//   Reset: control registers return to their defaults, sums, history,
//   pending and started flags clear, both channels go empty. Samples are
//   reported as ignored until the first read request.
module pointer_motion_filter_accumulator
   import pmfa_pkg::*;
#(
   parameter int HISTORY_DEPTH = 5
) (
   input  logic               clock,
   input  logic               reset,
   // request channel
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_action,
   input  logic signed [31:0] req_delta_x,
   input  logic signed [31:0] req_delta_y,
   // response channel
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [1:0]         rsp_status,
   output logic signed [31:0] rsp_out_x,
   output logic signed [31:0] rsp_out_y,
   // control register writes
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [1:0]         csr_index,
   input  logic [7:0]         csr_data
);

   localparam int SLOT_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
   localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(HISTORY_DEPTH - 1);
   localparam int BUF_DEPTH = 3;
   localparam logic [1:0] PTR_LAST = 2'(BUF_DEPTH - 1);
   localparam logic [2:0] BUF_LIMIT = 3'(BUF_DEPTH);

   // control registers
   logic [7:0] clamp_limit_ff, small_move_ff, boost_below_ff;
   logic [3:0] boost_gain_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         clamp_limit_ff <= CLAMP_LIMIT_RST;
         small_move_ff  <= SMALL_MOVE_RST;
         boost_below_ff <= BOOST_BELOW_RST;
         boost_gain_ff  <= BOOST_GAIN_RST;
      end else if (csr_valid && csr_ready) begin
         unique case (reg_index_type'(csr_index))
            REG_CLAMP_LIMIT: clamp_limit_ff <= csr_data;
            REG_SMALL_MOVE:  small_move_ff  <= csr_data;
            REG_BOOST_BELOW: boost_below_ff <= csr_data;
            REG_BOOST_GAIN:  boost_gain_ff  <= csr_data[3:0];
            default: ;
         endcase
      end
   end

   // input register
   logic               stage_valid_ff;
   logic               stage_action_ff;
   logic signed [31:0] stage_dx_ff, stage_dy_ff;
   logic [1:0]         buf_count_ff;
   logic               req_fire;

   assign req_ready = ({1'b0, buf_count_ff} + {2'b0, stage_valid_ff}) < BUF_LIMIT;
   assign req_fire  = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else begin
         stage_valid_ff <= req_fire;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         stage_action_ff <= req_action;
         stage_dx_ff     <= req_delta_x;
         stage_dy_ff     <= req_delta_y;
      end
   end

   // filter state
   logic                     started_ff, started_in;
   logic                     pending_ff, pending_in;
   logic [SLOT_W-1:0]        slot_ff, slot_in;
   logic [HISTORY_DEPTH-1:0] x_hist_ff, x_hist_in;
   logic [HISTORY_DEPTH-1:0] y_hist_ff, y_hist_in;
   logic signed [31:0]       sum_x_ff, sum_x_in;
   logic signed [31:0]       sum_y_ff, sum_y_in;

   // clamp each axis to +/- clamp limit
   logic signed [31:0] lim_pos, lim_neg;
   logic signed [8:0]  cx, cy;

   assign lim_pos = $signed({24'd0, clamp_limit_ff});
   assign lim_neg = -lim_pos;

   always_comb begin
      if (stage_dx_ff > lim_pos) begin
         cx = 9'(lim_pos);
      end else if (stage_dx_ff < lim_neg) begin
         cx = 9'(lim_neg);
      end else begin
         cx = 9'(stage_dx_ff);
      end
      if (stage_dy_ff > lim_pos) begin
         cy = 9'(lim_pos);
      end else if (stage_dy_ff < lim_neg) begin
         cy = 9'(lim_neg);
      end else begin
         cy = 9'(stage_dy_ff);
      end
   end

   // rest filter and boost per axis
   logic [SLOT_W-1:0] slot_cur;
   axis_result_type   fx, fy;
   logic              sample_nz, filt_nz;
   logic signed [31:0] fx32, fy32;

   assign slot_cur  = (slot_ff <= SLOT_LAST) ? slot_ff : '0;
   assign sample_nz = (cx != '0) || (cy != '0);
   assign fx = filter_axis(cx, &x_hist_ff, small_move_ff, boost_below_ff, boost_gain_ff);
   assign fy = filter_axis(cy, &y_hist_ff, small_move_ff, boost_below_ff, boost_gain_ff);
   assign fx32 = 32'(fx.val);
   assign fy32 = 32'(fy.val);
   assign filt_nz = (fx.val != '0) || (fy.val != '0);

   // next state and response beat
   rsp_beat_type beat;
   logic         buf_push;

   assign buf_push = stage_valid_ff;

   always_comb begin
      started_in  = started_ff;
      pending_in  = pending_ff;
      slot_in     = slot_ff;
      x_hist_in   = x_hist_ff;
      y_hist_in   = y_hist_ff;
      sum_x_in    = sum_x_ff;
      sum_y_in    = sum_y_ff;
      beat.status = ST_OK;
      beat.x      = '0;
      beat.y      = '0;
      if (stage_valid_ff) begin
         if (stage_action_ff == ACT_READ) begin
            started_in = 1'b1;
            if (pending_ff) begin
               beat.x     = sum_x_ff;
               beat.y     = sum_y_ff;
               sum_x_in   = '0;
               sum_y_in   = '0;
               pending_in = 1'b0;
            end else begin
               beat.status = ST_EMPTY;
            end
         end else if (!started_ff) begin
            beat.status = ST_IGNORED;
         end else if (sample_nz) begin
            if (fx.rest) begin
               x_hist_in[slot_cur] = 1'b1;
            end else if (fx.jitter) begin
               x_hist_in[slot_cur] = 1'b0;
            end
            if (fy.rest) begin
               y_hist_in[slot_cur] = 1'b1;
            end else if (fy.jitter) begin
               y_hist_in[slot_cur] = 1'b0;
            end
            slot_in = (slot_cur == SLOT_LAST) ? '0 : slot_cur + 1'b1;
            beat.x  = fx32;
            beat.y  = fy32;
            if (filt_nz) begin
               sum_x_in   = sum_x_ff + fx32;
               sum_y_in   = sum_y_ff + fy32;
               pending_in = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         started_ff <= 1'b0;
         pending_ff <= 1'b0;
         slot_ff    <= '0;
         x_hist_ff  <= '0;
         y_hist_ff  <= '0;
         sum_x_ff   <= '0;
         sum_y_ff   <= '0;
      end else begin
         started_ff <= started_in;
         pending_ff <= pending_in;
         slot_ff    <= slot_in;
         x_hist_ff  <= x_hist_in;
         y_hist_ff  <= y_hist_in;
         sum_x_ff   <= sum_x_in;
         sum_y_ff   <= sum_y_in;
      end
   end

   // response buffer, circular over three entries
   rsp_beat_type buf_ff [BUF_DEPTH];
   logic [1:0]   wr_ptr_ff, rd_ptr_ff;
   logic         buf_pop;

   assign rsp_valid  = (buf_count_ff != 2'd0);
   assign buf_pop    = rsp_valid && rsp_ready;
   assign rsp_status = buf_ff[rd_ptr_ff].status;
   assign rsp_out_x  = buf_ff[rd_ptr_ff].x;
   assign rsp_out_y  = buf_ff[rd_ptr_ff].y;

   always_ff @(posedge clock) begin
      if (buf_push) begin
         buf_ff[wr_ptr_ff] <= beat;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff    <= '0;
         rd_ptr_ff    <= '0;
         buf_count_ff <= '0;
      end else begin
         if (buf_push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_LAST) ? 2'd0 : wr_ptr_ff + 2'd1;
         end
         if (buf_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_LAST) ? 2'd0 : rd_ptr_ff + 2'd1;
         end
         case ({buf_push, buf_pop})
            2'b10:   buf_count_ff <= buf_count_ff + 2'd1;
            2'b01:   buf_count_ff <= buf_count_ff - 2'd1;
            default: buf_count_ff <= buf_count_ff;
         endcase
      end
   end

   // checks
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      buf_push |-> (buf_count_ff < 2'(BUF_DEPTH)) || buf_pop)
      else $error("response buffer written while full");

   a_read_clears: assert property (@(posedge clock) disable iff (reset)
      stage_valid_ff && (stage_action_ff == ACT_READ) && pending_ff
      |=> (sum_x_ff == '0) && (sum_y_ff == '0) && !pending_ff)
      else $error("read did not clear the sums");

   a_pending_needs_start: assert property (@(posedge clock) disable iff (reset)
      pending_ff |-> started_ff)
      else $error("motion pending before the first read");

   a_ignored_state_kept: assert property (@(posedge clock) disable iff (reset)
      stage_valid_ff && (beat.status == ST_IGNORED)
      |=> $stable(sum_x_ff) && $stable(sum_y_ff) && $stable(slot_ff))
      else $error("ignored sample changed filter state");

endmodule

// File: bench/tb_top.sv
// tb_top: self-checking bench for pointer_motion_filter_accumulator; drives
// samples, reads and register writes and checks every response beat against
// its own motion predictor; depends on pmfa_pkg and the rtl top level
`timescale 1ns / 1ps

module tb_top;
   import pmfa_pkg::*;

   localparam int HIST_DEPTH  = 5;
   localparam int STUCK_LIMIT = 4000;
   localparam int PHASES      = 9;
   localparam int PHASE_BEATS = 190;

   // tracks filter state and holds the response beats still owed by the block
   class motion_checker;
      rsp_beat_type            owed_beats[$];
      int                      errors;
      logic [7:0]              clamp_lim;
      logic [7:0]              small_lim;
      logic [7:0]              boost_thr;
      logic [3:0]              gain;
      bit                      started;
      bit                      moved;
      logic [2:0]              slot;
      logic [HIST_DEPTH-1:0]   x_hist;
      logic [HIST_DEPTH-1:0]   y_hist;
      logic [31:0]             acc_x;
      logic [31:0]             acc_y;

      function new();
         errors    = 0;
         clamp_lim = CLAMP_LIMIT_RST;
         small_lim = SMALL_MOVE_RST;
         boost_thr = BOOST_BELOW_RST;
         gain      = BOOST_GAIN_RST;
         started   = 0;
         moved     = 0;
         slot      = '0;
         x_hist    = '0;
         y_hist    = '0;
         acc_x     = '0;
         acc_y     = '0;
      endfunction

      function void write_reg(reg_index_type idx, logic [7:0] data);
         case (idx)
            REG_CLAMP_LIMIT: clamp_lim = data;
            REG_SMALL_MOVE:  small_lim = data;
            REG_BOOST_BELOW: boost_thr = data;
            REG_BOOST_GAIN:  gain      = data[3:0];
            default: ;
         endcase
      endfunction

      function int clamp_axis(logic signed [31:0] raw);
         int v;
         int lim;
         v   = raw;
         lim = int'(clamp_lim);
         if (v > lim) return lim;
         if (v < -lim) return -lim;
         return v;
      endfunction

      // rest filter then boost for one clamped axis
      function int filter_axis(int v, inout logic [HIST_DEPTH-1:0] hist,
                               input logic [2:0] sl);
         int mag;
         mag = (v < 0) ? -v : v;
         if (mag == 0) begin
            hist[sl] = 1'b1;
         end else if (mag <= int'(small_lim)) begin
            if (hist == {HIST_DEPTH{1'b1}}) begin
               v   = 0;
               mag = 0;
            end
            hist[sl] = 1'b0;
         end
         if (mag < int'(boost_thr)) v = v * int'(gain);
         return v;
      endfunction

      function void note_request(action_type act, logic [31:0] dx, logic [31:0] dy);
         rsp_beat_type e;
         int           cx;
         int           cy;
         logic [2:0]   sl;
         e.status = ST_OK;
         e.x      = '0;
         e.y      = '0;
         if (act == ACT_READ) begin
            started = 1;
            if (moved) begin
               e.x   = acc_x;
               e.y   = acc_y;
               acc_x = '0;
               acc_y = '0;
               moved = 0;
            end else begin
               e.status = ST_EMPTY;
            end
         end else if (!started) begin
            e.status = ST_IGNORED;
         end else begin
            cx = clamp_axis(dx);
            cy = clamp_axis(dy);
            // an all-zero sample leaves every piece of state alone
            if (cx != 0 || cy != 0) begin
               sl   = (slot < HIST_DEPTH) ? slot : 3'd0;
               cx   = filter_axis(cx, x_hist, sl);
               cy   = filter_axis(cy, y_hist, sl);
               slot = (sl + 1 < HIST_DEPTH) ? sl + 3'd1 : 3'd0;
               e.x  = cx;
               e.y  = cy;
               if (cx != 0 || cy != 0) begin
                  acc_x = acc_x + 32'(cx);
                  acc_y = acc_y + 32'(cy);
                  moved = 1;
               end
            end
         end
         owed_beats.push_back(e);
      endfunction

      function void check_response(logic [1:0] st, logic [31:0] x, logic [31:0] y);
         rsp_beat_type e;
         if (owed_beats.size() == 0) begin
            $error("response beat with none expected: status %0d x %0d y %0d",
                   st, $signed(x), $signed(y));
            errors++;
            return;
         end
         e = owed_beats.pop_front();
         if (st !== e.status) begin
            $error("status: expected %0d, got %0d", e.status, st);
            errors++;
         end
         if (x !== e.x) begin
            $error("out_x: expected %0d, got %0d", e.x, $signed(x));
            errors++;
         end
         if (y !== e.y) begin
            $error("out_y: expected %0d, got %0d", e.y, $signed(y));
            errors++;
         end
      endfunction
   endclass

   logic               clock       = 1'b0;
   logic               reset       = 1'b1;
   logic               req_valid   = 1'b0;
   logic               req_ready;
   logic               req_action  = 1'b0;
   logic signed [31:0] req_delta_x = '0;
   logic signed [31:0] req_delta_y = '0;
   logic               rsp_valid;
   logic               rsp_ready   = 1'b0;
   logic [1:0]         rsp_status;
   logic signed [31:0] rsp_out_x;
   logic signed [31:0] rsp_out_y;
   logic               csr_valid   = 1'b0;
   logic               csr_ready;
   logic [1:0]         csr_index   = '0;
   logic [7:0]         csr_data    = '0;

   motion_checker checker_h = new();
   int            req_idle_pct = 13;
   int            rsp_idle_pct = 68;
   bit            hold_req     = 0;
   int            hold_left    = 0;
   int            stuck_cycles = 0;

   // per phase register settings, extremes included
   int clamp_set[PHASES] = '{96, 1, 255, 40, 255, 8, 200, 1, 17};
   int small_set[PHASES] = '{2, 0, 255, 5, 0, 3, 255, 1, 9};
   int below_set[PHASES] = '{80, 0, 255, 100, 255, 0, 30, 128, 60};
   int gain_set[PHASES]  = '{4, 1, 15, 2, 15, 7, 1, 3, 11};

   pointer_motion_filter_accumulator dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_action  (req_action),
      .req_delta_x (req_delta_x),
      .req_delta_y (req_delta_y),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_status  (rsp_status),
      .rsp_out_x   (rsp_out_x),
      .rsp_out_y   (rsp_out_y),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data)
   );

   always #5 clock = ~clock;

   // receiver: random stalls, plus a long hold-off on request
   always @(negedge clock) begin
      if (hold_req) begin
         hold_left = 80;
         hold_req  = 0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= rsp_idle_pct);
      end
   end

   // response beat checker
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         checker_h.check_response(rsp_status, rsp_out_x, rsp_out_y);
   end

   // watchdog on cycles without any accepted beat
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready))
         stuck_cycles = 0;
      else
         stuck_cycles++;
      if (stuck_cycles >= STUCK_LIMIT) begin
         $display("tb_top: errors");
         $finish;
      end
   end

   // offer one request beat, with idle cycles before it at the sender's idle rate
   task automatic send_req(action_type act, logic [31:0] dx, logic [31:0] dy);
      int gap;
      gap = 0;
      while ($urandom_range(99) < req_idle_pct) gap++;
      @(negedge clock);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_action  <= act;
      req_delta_x <= dx;
      req_delta_y <= dy;
      do @(posedge clock); while (!req_ready);
      checker_h.note_request(act, dx, dy);
   endtask

   task automatic write_csr(reg_index_type idx, logic [7:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      checker_h.write_reg(idx, data);
   endtask

   // drop valids and let every owed response drain
   task automatic wait_idle();
      @(negedge clock);
      req_valid <= 1'b0;
      csr_valid <= 1'b0;
      while (checker_h.owed_beats.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   function automatic logic [31:0] signed_mag(int mag);
      return $urandom_range(1) ? 32'(-mag) : 32'(mag);
   endfunction

   // one axis value: rest, jitter, in range, wide or extreme
   function automatic logic [31:0] pick_axis();
      int r;
      r = $urandom_range(99);
      if (r < 25) return '0;
      if (r < 50) return signed_mag($urandom_range(1, int'(checker_h.small_lim) + 1));
      if (r < 72) return signed_mag($urandom_range(1, int'(checker_h.clamp_lim) + 2));
      if (r < 84) return $urandom();
      if (r < 90) begin
         case ($urandom_range(3))
            0: return 32'h7fff_ffff;
            1: return 32'h8000_0000;
            2: return 32'hffff_ffff;
            default: return 32'h0000_0001;
         endcase
      end
      return signed_mag($urandom_range(0, 255));
   endfunction

   // a read, a single sample, or a rest run on one axis ended by a small move
   task automatic send_random(output int n);
      int          r;
      int          k;
      bit          on_x;
      logic [31:0] busy;
      logic [31:0] jit;
      r = $urandom_range(99);
      if (r < 10) begin
         send_req(ACT_READ, $urandom(), $urandom());
         n = 1;
      end else if (r < 30) begin
         k    = $urandom_range(3, 6);
         on_x = $urandom_range(1);
         for (int j = 0; j < k; j++) begin
            busy = signed_mag($urandom_range(1, 300));
            if (on_x) send_req(ACT_SAMPLE, '0, busy);
            else send_req(ACT_SAMPLE, busy, '0);
         end
         jit = signed_mag($urandom_range(1, checker_h.small_lim == 0 ? 1 :
                                            int'(checker_h.small_lim)));
         if (on_x) send_req(ACT_SAMPLE, jit, pick_axis());
         else send_req(ACT_SAMPLE, pick_axis(), jit);
         n = k + 1;
      end else begin
         send_req(ACT_SAMPLE, pick_axis(), pick_axis());
         n = 1;
      end
   endtask

   initial begin
      int sent;
      int n;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: ignored samples, first read, clamp and boost edges, rest drop
      send_req(ACT_SAMPLE, 32'h7fff_ffff, 32'h8000_0000);
      send_req(ACT_SAMPLE, '0, '0);
      send_req(ACT_READ, $urandom(), $urandom());
      send_req(ACT_SAMPLE, '0, '0);
      send_req(ACT_SAMPLE, 32'h7fff_ffff, 32'h8000_0000);
      send_req(ACT_SAMPLE, 32'(-80), 32'd79);
      send_req(ACT_READ, '0, '0);
      send_req(ACT_READ, 32'hffff_ffff, 32'hffff_ffff);
      repeat (5) send_req(ACT_SAMPLE, '0, 32'd50);
      send_req(ACT_SAMPLE, 32'd1, '0);
      send_req(ACT_SAMPLE, 32'd2, 32'(-2));
      send_req(ACT_SAMPLE, 32'd3, '0);
      send_req(ACT_SAMPLE, 32'hffff_ffff, 32'd1);
      send_req(ACT_READ, '0, '0);
      wait_idle();

      // zero clamp bound flattens every sample
      write_csr(REG_CLAMP_LIMIT, 8'd0);
      @(negedge clock);
      csr_valid <= 1'b0;
      send_req(ACT_SAMPLE, 32'd5, 32'(-5));
      send_req(ACT_SAMPLE, 32'h8000_0000, 32'h7fff_ffff);
      send_req(ACT_READ, '0, '0);
      wait_idle();

      // random phases over register settings and idling regimes
      for (int p = 0; p < PHASES; p++) begin
         case (p / 3)
            0: begin req_idle_pct = 13; rsp_idle_pct = 68; end
            1: begin req_idle_pct = 68; rsp_idle_pct = 13; end
            default: begin req_idle_pct = 0; rsp_idle_pct = 0; end
         endcase
         write_csr(REG_CLAMP_LIMIT, 8'(clamp_set[p]));
         write_csr(REG_SMALL_MOVE, 8'(small_set[p]));
         write_csr(REG_BOOST_BELOW, 8'(below_set[p]));
         write_csr(REG_BOOST_GAIN, 8'(gain_set[p]));
         @(negedge clock);
         csr_valid <= 1'b0;
         sent = 0;
         while (sent < PHASE_BEATS) begin
            if (sent >= 40 && sent < 40 + 7 && p % 3 == 2) hold_req = 1;
            send_random(n);
            sent += n;
         end
         wait_idle();
      end

      repeat (6) @(posedge clock);
      if (checker_h.errors == 0)
         $display("tb_top: clean");
      else
         $display("tb_top: errors");
      $finish;
   end

endmodule
